// File: design/edce_pkg.sv
package edce_pkg;

    localparam int ORIGIN_YEAR = 1970;
    localparam int YEAR_SPAN   = 256;
    localparam int LAST_YEAR   = ORIGIN_YEAR + YEAR_SPAN - 1;
    localparam int COUNT_MAX   = 131071;

    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WDAY_W  = 3;
    localparam int COUNT_W = 17;
    localparam int AMT_W   = 18;
    localparam int FUNC_W  = 3;
    localparam int STS_W   = 3;
    localparam int YLEN_W  = 9;

    // year offset from origin and month total on the continuous month scale
    localparam int YOFF_W = $clog2(YEAR_SPAN);
    localparam int MTOT_W = $clog2(YEAR_SPAN * 12);

    // divide by 12 through a reciprocal, months total stays below YEAR_SPAN * 12
    localparam int M12_SH    = MTOT_W + 4;
    localparam int M12_RCP   = ((1 << M12_SH) + 11) / 12;
    localparam int M12_RCP_W = $clog2(M12_RCP + 1);
    localparam int M12_P_W   = MTOT_W + M12_RCP_W;

    // modulo 7 through a reciprocal for the weekday
    localparam int W7_SH    = COUNT_W + 3;
    localparam int W7_RCP   = ((1 << W7_SH) + 6) / 7;
    localparam int W7_RCP_W = $clog2(W7_RCP + 1);
    localparam int W7_P_W   = COUNT_W + W7_RCP_W;
    localparam int W7_Q_W   = W7_P_W - W7_SH;

    function automatic int f_last_day();
        int total;
        total = 0;
        for (int y = ORIGIN_YEAR; y < ORIGIN_YEAR + YEAR_SPAN; y++) begin
            if (total <= COUNT_MAX + 1) begin
                if ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) total = total + 366;
                else total = total + 365;
            end
        end
        total = total - 1;
        return (total > COUNT_MAX) ? COUNT_MAX : total;
    endfunction

    localparam int LAST_DAY = f_last_day();

    typedef enum logic [FUNC_W-1:0] {
        FN_SET        = 3'd0,
        FN_ADD_YEARS  = 3'd1,
        FN_ADD_MONTHS = 3'd2,
        FN_ADD_DAYS   = 3'd3,
        FN_READ       = 3'd4
    } t_func;

    typedef enum logic [STS_W-1:0] {
        STS_OK        = 3'd0,
        STS_BEFORE    = 3'd1,
        STS_BAD_DAY   = 3'd2,
        STS_PAST      = 3'd3,
        STS_BAD_MONTH = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_MDIV, S_TC_YEAR, S_TC_MON,
        S_TD_YEAR, S_TD_MON, S_WD_MUL, S_WD_SUB, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_CHECK, OP_MDIV, OP_TC_YEAR, OP_TC_MON,
        OP_TD_YEAR, OP_TD_MON, OP_WD_MUL, OP_WD_SUB
    } t_dp_op;

    typedef struct packed {
        logic fail;
        logic go_div;
        logic go_tc;
        logic go_td;
        logic ty_done;
        logic tm_done;
        logic dy_done;
        logic dm_done;
    } t_dp_sts;

    // century test by compare, the rest by low bits
    function automatic logic f_is_leap(input logic [YEAR_W-1:0] y);
        logic cent;
        cent = 1'b0;
        for (int k = 0; k <= 40; k++) begin
            if (y == YEAR_W'(k * 100)) cent = 1'b1;
        end
        return (y[1:0] == 2'd0) && (!cent || y[3:0] == 4'd0);
    endfunction

    function automatic logic [YLEN_W-1:0] f_year_len(input logic [YEAR_W-1:0] y);
        return f_is_leap(y) ? YLEN_W'(366) : YLEN_W'(365);
    endfunction

    function automatic logic [DAY_W-1:0] f_month_len(input logic [YEAR_W-1:0] y,
                                                     input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2: begin
                len = f_is_leap(y) ? DAY_W'(29) : DAY_W'(28);
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                len = DAY_W'(30);
            end
            default: begin
                len = DAY_W'(31);
            end
        endcase
        return len;
    endfunction

endpackage

// File: design/edce_if.sv
interface edce_req_if;
    logic                                valid;
    logic                                ready;
    logic [edce_pkg::FUNC_W-1:0]         func;
    logic [edce_pkg::YEAR_W-1:0]         set_year;
    logic [edce_pkg::MONTH_W-1:0]        set_month;
    logic [edce_pkg::DAY_W-1:0]          set_day;
    logic signed [edce_pkg::AMT_W-1:0]   amount;

    modport source (output valid, func, set_year, set_month, set_day, amount,
                    input ready);
    modport sink   (input valid, func, set_year, set_month, set_day, amount,
                    output ready);
endinterface

interface edce_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [edce_pkg::YEAR_W-1:0]     year;
    logic [edce_pkg::MONTH_W-1:0]    month;
    logic [edce_pkg::DAY_W-1:0]      day;
    logic [edce_pkg::WDAY_W-1:0]     weekday;
    logic [edce_pkg::COUNT_W-1:0]    day_count;
    logic [edce_pkg::STS_W-1:0]      status;

    modport source (output valid, year, month, day, weekday, day_count, status,
                    input ready);
    modport sink   (input valid, year, month, day, weekday, day_count, status,
                    output ready);
endinterface

// File: design/edce_ctrl.sv
module edce_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  edce_pkg::t_dp_sts i_sts,
    output edce_pkg::t_dp_op  o_op
);
    import edce_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_op        = OP_NONE;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_op = OP_CHECK;
                if (i_sts.fail)        n_state = S_OUT;
                else if (i_sts.go_div) n_state = S_MDIV;
                else if (i_sts.go_tc)  n_state = S_TC_YEAR;
                else if (i_sts.go_td)  n_state = S_TD_YEAR;
                else                   n_state = S_OUT;
            end
            S_MDIV: begin
                o_op    = OP_MDIV;
                n_state = S_TC_YEAR;
            end
            S_TC_YEAR: begin
                o_op = OP_TC_YEAR;
                if (i_sts.ty_done) n_state = S_TC_MON;
            end
            S_TC_MON: begin
                o_op = OP_TC_MON;
                if (i_sts.tm_done) n_state = S_TD_YEAR;
            end
            S_TD_YEAR: begin
                o_op = OP_TD_YEAR;
                if (i_sts.dy_done) n_state = S_TD_MON;
            end
            S_TD_MON: begin
                o_op = OP_TD_MON;
                if (i_sts.dm_done) n_state = S_WD_MUL;
            end
            S_WD_MUL: begin
                o_op    = OP_WD_MUL;
                n_state = S_WD_SUB;
            end
            S_WD_SUB: begin
                o_op    = OP_WD_SUB;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_starts_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == S_CHECK))
        else $error("accepted transaction did not start a check");
    a_one_side_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while a result is pending");
    a_fail_goes_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && i_sts.fail) |=> (r_state == S_OUT))
        else $error("failed check did not go straight to the result");
`endif

endmodule

// File: design/edce_datapath.sv
module edce_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  edce_pkg::t_dp_op                 i_op,
    input  logic [edce_pkg::FUNC_W-1:0]      i_func,
    input  logic [edce_pkg::YEAR_W-1:0]      i_set_year,
    input  logic [edce_pkg::MONTH_W-1:0]     i_set_month,
    input  logic [edce_pkg::DAY_W-1:0]       i_set_day,
    input  logic signed [edce_pkg::AMT_W-1:0] i_amount,
    output edce_pkg::t_dp_sts                o_sts,
    output logic [edce_pkg::YEAR_W-1:0]      o_year,
    output logic [edce_pkg::MONTH_W-1:0]     o_month,
    output logic [edce_pkg::DAY_W-1:0]       o_day,
    output logic [edce_pkg::WDAY_W-1:0]      o_weekday,
    output logic [edce_pkg::COUNT_W-1:0]     o_day_count,
    output logic [edce_pkg::STS_W-1:0]       o_status
);
    import edce_pkg::*;

    localparam int SUM_W = AMT_W + 1;

    // stored date and its decoded form
    logic [COUNT_W-1:0] r_count;
    logic [YEAR_W-1:0]  r_y;
    logic [MONTH_W-1:0] r_m;
    logic [DAY_W-1:0]   r_d;
    logic [WDAY_W-1:0]  r_wd;
    t_status            r_status;

    // latched transaction
    t_func              r_func;
    logic [YEAR_W-1:0]  r_sy;
    logic [MONTH_W-1:0] r_sm;
    logic [DAY_W-1:0]   r_sd;
    logic [AMT_W-1:0]   r_amt;

    // walk and target registers
    logic [YEAR_W-1:0]  r_ty, r_wy;
    logic [MONTH_W-1:0] r_tm, r_wm;
    logic [DAY_W-1:0]   r_td;
    logic [COUNT_W-1:0] r_acc;
    logic [MTOT_W-1:0]  r_mtot;
    logic [M12_P_W-1:0] r_mprod;
    logic [COUNT_W-1:0] r_wx;
    logic [W7_P_W-1:0]  r_wprod;

    // check stage
    logic signed [SUM_W-1:0] c_ny, c_sum, c_mtot;
    logic [SUM_W-1:0]        c_amt_x;
    logic [YOFF_W-1:0]       c_yoff;
    t_status                 c_status;
    logic                    c_go_div, c_go_tc, c_go_td;
    logic [YEAR_W-1:0]       c_ty;
    logic [MONTH_W-1:0]      c_tm;
    logic [DAY_W-1:0]        c_td;

    // month division stage
    logic [YOFF_W-1:0]  c_q;
    logic [MONTH_W-1:0] c_rem, c_mm;
    logic [YEAR_W-1:0]  c_my;

    logic [COUNT_W-1:0] c_fresh;
    logic [W7_Q_W-1:0]  c_wq;

    always_comb begin
        c_amt_x  = {r_amt[AMT_W-1], r_amt};
        c_ny     = signed'(SUM_W'(r_y)) + signed'(c_amt_x);
        c_sum    = signed'(SUM_W'(r_count)) + signed'(c_amt_x);
        c_yoff   = YOFF_W'(r_y - YEAR_W'(ORIGIN_YEAR));
        c_mtot   = signed'(SUM_W'({c_yoff, 3'b000}) + SUM_W'({c_yoff, 2'b00})
                   + SUM_W'(r_m - 4'd1) + c_amt_x);
        c_status = STS_OK;
        c_go_div = 1'b0;
        c_go_tc  = 1'b0;
        c_go_td  = 1'b0;
        c_ty     = r_sy;
        c_tm     = r_sm;
        c_td     = r_sd;
        case (r_func)
            FN_SET: begin
                if (r_sm == 4'd0 || r_sm > 4'd12)               c_status = STS_BAD_MONTH;
                else if (r_sy < YEAR_W'(ORIGIN_YEAR))            c_status = STS_BEFORE;
                else if (r_sy > YEAR_W'(LAST_YEAR))              c_status = STS_PAST;
                else if (r_sd == 5'd0 || r_sd > f_month_len(r_sy, r_sm))
                                                                 c_status = STS_BAD_DAY;
                else                                             c_go_tc  = 1'b1;
            end
            FN_ADD_YEARS: begin
                if (r_amt != '0) begin
                    if (c_ny < SUM_W'(ORIGIN_YEAR))      c_status = STS_BEFORE;
                    else if (c_ny > SUM_W'(LAST_YEAR))   c_status = STS_PAST;
                    else begin
                        c_ty    = c_ny[YEAR_W-1:0];
                        c_tm    = r_m;
                        c_td    = r_d;
                        // leap day into a common year moves to march 1
                        if (r_m == 4'd2 && r_d == 5'd29 && !f_is_leap(c_ny[YEAR_W-1:0])) begin
                            c_tm = 4'd3;
                            c_td = 5'd1;
                        end
                        c_go_tc = 1'b1;
                    end
                end
            end
            FN_ADD_MONTHS: begin
                if (r_amt != '0) begin
                    if (c_mtot < 0)                          c_status = STS_BEFORE;
                    else if (c_mtot >= SUM_W'(YEAR_SPAN * 12)) c_status = STS_PAST;
                    else                                     c_go_div = 1'b1;
                end
            end
            FN_ADD_DAYS: begin
                if (c_sum < 0)                           c_status = STS_BEFORE;
                else if (c_sum > SUM_W'(LAST_DAY))       c_status = STS_PAST;
                else                                     c_go_td  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        c_q   = YOFF_W'(r_mprod >> M12_SH);
        c_rem = MONTH_W'(r_mtot - MTOT_W'({c_q, 3'b000}) - MTOT_W'({c_q, 2'b00}));
        c_my  = YEAR_W'(ORIGIN_YEAR) + YEAR_W'(c_q);
        c_mm  = c_rem + 4'd1;
    end

    assign c_fresh = r_acc + COUNT_W'(r_td) - COUNT_W'(1);
    assign c_wq    = W7_Q_W'(r_wprod >> W7_SH);

    always_comb begin
        o_sts.fail    = (c_status != STS_OK);
        o_sts.go_div  = c_go_div;
        o_sts.go_tc   = c_go_tc;
        o_sts.go_td   = c_go_td;
        o_sts.ty_done = (r_wy >= r_ty);
        o_sts.tm_done = (r_wm >= r_tm);
        o_sts.dy_done = (r_acc < COUNT_W'(f_year_len(r_wy)));
        o_sts.dm_done = (r_wm == 4'd12) || (r_acc < COUNT_W'(f_month_len(r_wy, r_wm)));
    end

    // date state, reset to the origin
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_y      <= YEAR_W'(ORIGIN_YEAR);
            r_m      <= 4'd1;
            r_d      <= 5'd1;
            r_wd     <= 3'd4;
            r_status <= STS_OK;
        end else begin
            case (i_op)
                OP_CHECK: begin
                    r_status <= c_status;
                    if (c_go_td) r_count <= c_sum[COUNT_W-1:0];
                end
                OP_TC_MON: begin
                    if (r_wm >= r_tm) r_count <= c_fresh;
                end
                OP_TD_MON: begin
                    if (!((r_wm == 4'd12) || (r_acc < COUNT_W'(f_month_len(r_wy, r_wm))))) begin
                    end else begin
                        r_y <= r_wy;
                        r_m <= r_wm;
                        r_d <= DAY_W'(r_acc) + 5'd1;
                    end
                end
                OP_WD_SUB: begin
                    r_wd <= WDAY_W'(r_wx - COUNT_W'({c_wq, 3'b000}) + COUNT_W'(c_wq));
                end
                default: begin
                end
            endcase
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_func <= t_func'(i_func);
                r_sy   <= i_set_year;
                r_sm   <= i_set_month;
                r_sd   <= i_set_day;
                r_amt  <= i_amount;
            end
            OP_CHECK: begin
                r_ty    <= c_ty;
                r_tm    <= c_tm;
                r_td    <= c_td;
                r_wy    <= YEAR_W'(ORIGIN_YEAR);
                r_wm    <= 4'd1;
                r_mtot  <= c_mtot[MTOT_W-1:0];
                r_mprod <= M12_P_W'(c_mtot[MTOT_W-1:0]) * M12_P_W'(M12_RCP);
                r_acc   <= c_go_td ? c_sum[COUNT_W-1:0] : '0;
            end
            OP_MDIV: begin
                r_ty <= c_my;
                // a day past the end of the month rolls to the 1st of the next
                if (r_d > f_month_len(c_my, c_mm)) begin
                    r_tm <= c_mm + 4'd1;
                    r_td <= 5'd1;
                end else begin
                    r_tm <= c_mm;
                    r_td <= r_d;
                end
            end
            OP_TC_YEAR: begin
                if (r_wy < r_ty) begin
                    r_acc <= r_acc + COUNT_W'(f_year_len(r_wy));
                    r_wy  <= r_wy + 12'd1;
                end
            end
            OP_TC_MON: begin
                if (r_wm < r_tm) begin
                    r_acc <= r_acc + COUNT_W'(f_month_len(r_ty, r_wm));
                    r_wm  <= r_wm + 4'd1;
                end else begin
                    r_acc <= c_fresh;
                    r_wy  <= YEAR_W'(ORIGIN_YEAR);
                end
            end
            OP_TD_YEAR: begin
                if (r_acc >= COUNT_W'(f_year_len(r_wy))) begin
                    r_acc <= r_acc - COUNT_W'(f_year_len(r_wy));
                    r_wy  <= r_wy + 12'd1;
                end else begin
                    r_wm <= 4'd1;
                end
            end
            OP_TD_MON: begin
                if (r_wm != 4'd12 && r_acc >= COUNT_W'(f_month_len(r_wy, r_wm))) begin
                    r_acc <= r_acc - COUNT_W'(f_month_len(r_wy, r_wm));
                    r_wm  <= r_wm + 4'd1;
                end
            end
            OP_WD_MUL: begin
                r_wx    <= r_count + COUNT_W'(4);
                r_wprod <= W7_P_W'(r_count + COUNT_W'(4)) * W7_P_W'(W7_RCP);
            end
            default: begin
            end
        endcase
    end

    assign o_year      = r_y;
    assign o_month     = r_m;
    assign o_day       = r_d;
    assign o_weekday   = r_wd;
    assign o_day_count = r_count;
    assign o_status    = r_status;

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(LAST_DAY))
        else $error("day count beyond the last supported day");
    a_month_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m != 4'd0 && r_m <= 4'd12)
        else $error("stored month out of range");
    a_weekday_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wd <= 3'd6)
        else $error("weekday out of range");
    a_fail_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_CHECK && c_status != STS_OK) |=> $stable(r_count))
        else $error("error changed the stored date");
`endif

endmodule

// File: design/epoch_day_calendar_engine_unit.sv
// a set or an add of years walks the years and months up to the target to get the day count,
// then walks them again to decode it; an add of months first divides by 12 in S_MDIV
// add days walks the years once, to decode; a read or an error goes from the check to the result
// one transaction at a time, the next is taken once the result has been taken
// the time is set by the year walk of the shared day accumulator, one year a cycle
// reset (synchronous, active low) puts the date at 1970-01-01, a thursday
module epoch_day_calendar_engine_unit (
    input logic         i_clk,
    input logic         i_rst_n,
    edce_req_if.sink    i_req,
    edce_rsp_if.source  o_rsp
);
    import edce_pkg::*;

    t_dp_op  w_op;
    t_dp_sts w_sts;

    edce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (w_sts),
        .o_op        (w_op)
    );

    edce_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .i_func      (i_req.func),
        .i_set_year  (i_req.set_year),
        .i_set_month (i_req.set_month),
        .i_set_day   (i_req.set_day),
        .i_amount    (i_req.amount),
        .o_sts       (w_sts),
        .o_year      (o_rsp.year),
        .o_month     (o_rsp.month),
        .o_day       (o_rsp.day),
        .o_weekday   (o_rsp.weekday),
        .o_day_count (o_rsp.day_count),
        .o_status    (o_rsp.status)
    );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import edce_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #1 i_clk = ~i_clk;

    edce_req_if req_if ();
    edce_rsp_if rsp_if ();

    epoch_day_calendar_engine_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [YEAR_W-1:0]        set_year;
        logic [MONTH_W-1:0]       set_month;
        logic [DAY_W-1:0]         set_day;
        logic signed [AMT_W-1:0]  amount;
    } t_cmd;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [WDAY_W-1:0]  weekday;
        logic [COUNT_W-1:0] day_count;
        logic [STS_W-1:0]   status;
    } t_date_rsp;

    t_cmd      cmd_q[$];
    t_date_rsp date_q[$];
    int        stored_days;
    int        mismatches;
    int        cycle_cnt;
    bit        hold_go;
    bit        rx_hold;
    bit        hold_input;
    int        tx_gap;
    int        rx_gap;

    function automatic bit leap_year(int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int month_days(int y, int m);
        if (m == 2) return leap_year(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
        return 31;
    endfunction

    function automatic int max_day_count();
        int total;
        total = 0;
        for (int y = ORIGIN_YEAR; y < ORIGIN_YEAR + YEAR_SPAN; y++)
            if (total <= COUNT_MAX + 1) total += leap_year(y) ? 366 : 365;
        total -= 1;
        return total > COUNT_MAX ? COUNT_MAX : total;
    endfunction

    function automatic void split_days(int cnt, output int y, output int m, output int d);
        int rest;
        rest = cnt;
        y = ORIGIN_YEAR;
        m = 1;
        while (rest >= (leap_year(y) ? 366 : 365)) begin
            rest -= leap_year(y) ? 366 : 365;
            y++;
        end
        while (m < 12 && rest >= month_days(y, m)) begin
            rest -= month_days(y, m);
            m++;
        end
        d = rest + 1;
    endfunction

    function automatic int join_date(int y, int m, int d, output int cnt);
        int off;
        if (m < 1 || m > 12) return STS_BAD_MONTH;
        if (y < ORIGIN_YEAR) return STS_BEFORE;
        if (y >= ORIGIN_YEAR + YEAR_SPAN) return STS_PAST;
        if (d < 1 || d > month_days(y, m)) return STS_BAD_DAY;
        off = d - 1;
        for (int i = 1; i < m; i++) off += month_days(y, i);
        for (int i = ORIGIN_YEAR; i < y; i++) off += leap_year(i) ? 366 : 365;
        if (off > max_day_count()) return STS_PAST;
        cnt = off;
        return STS_OK;
    endfunction

    function automatic t_date_rsp calendar_step(t_cmd c);
        t_date_rsp r;
        int y, m, d, st, fresh, amt, ny, nm, nd, tot;
        split_days(stored_days, y, m, d);
        amt = int'(c.amount);
        st = STS_OK;
        fresh = stored_days;
        if (c.func == FN_SET) begin
            st = join_date(int'(c.set_year), int'(c.set_month), int'(c.set_day), fresh);
        end else if (c.func == FN_ADD_YEARS && amt != 0) begin
            ny = y + amt;
            if (ny < ORIGIN_YEAR) st = STS_BEFORE;
            else if (ny >= ORIGIN_YEAR + YEAR_SPAN) st = STS_PAST;
            else begin
                nm = m;
                nd = d;
                if (m == 2 && d == 29 && !leap_year(ny)) begin
                    nm = 3;
                    nd = 1;
                end
                st = join_date(ny, nm, nd, fresh);
            end
        end else if (c.func == FN_ADD_MONTHS && amt != 0) begin
            tot = (y - ORIGIN_YEAR) * 12 + (m - 1) + amt;
            if (tot < 0) st = STS_BEFORE;
            else begin
                ny = ORIGIN_YEAR + tot / 12;
                nm = tot % 12 + 1;
                nd = d;
                if (ny >= ORIGIN_YEAR + YEAR_SPAN) st = STS_PAST;
                else begin
                    if (nd > month_days(ny, nm)) begin
                        nm += 1;
                        nd = 1;
                    end
                    st = join_date(ny, nm, nd, fresh);
                end
            end
        end else if (c.func == FN_ADD_DAYS) begin
            tot = stored_days + amt;
            if (tot < 0) st = STS_BEFORE;
            else if (tot > max_day_count()) st = STS_PAST;
            else fresh = tot;
        end
        if (st == STS_OK) begin
            stored_days = fresh;
            split_days(stored_days, y, m, d);
        end
        r.year = YEAR_W'(y);
        r.month = MONTH_W'(m);
        r.day = DAY_W'(d);
        r.weekday = WDAY_W'((stored_days + 4) % 7);
        r.day_count = COUNT_W'(stored_days);
        r.status = STS_W'(st);
        return r;
    endfunction

    function automatic t_cmd make_cmd(int f, int y, int m, int d, int a);
        t_cmd c;
        c.func = FUNC_W'(f);
        c.set_year = YEAR_W'(y);
        c.set_month = MONTH_W'(m);
        c.set_day = DAY_W'(d);
        c.amount = AMT_W'(a);
        return c;
    endfunction

    function automatic void queue_cmd(t_cmd c);
        cmd_q.insert(cmd_q.size(), c);
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int pick;
        c = make_cmd(int'($urandom_range(0, 4)), int'($urandom_range(1970, 2225)),
                     int'($urandom_range(1, 12)), int'($urandom_range(1, 31)), 0);
        pick = $urandom_range(0, 19);
        if (pick == 0) c = t_cmd'(($bits(t_cmd))'({$urandom, $urandom}));
        else if (pick == 1) c.func = FUNC_W'($urandom_range(5, 7));
        else if (pick == 2) begin
            c.set_year = YEAR_W'($urandom);
            c.set_month = MONTH_W'($urandom);
            c.set_day = DAY_W'($urandom);
        end
        case (c.func)
            FN_ADD_YEARS:  c.amount = AMT_W'(int'($urandom_range(0, 80)) - 40);
            FN_ADD_MONTHS: c.amount = AMT_W'(int'($urandom_range(0, 1200)) - 600);
            FN_ADD_DAYS:   c.amount = (pick == 3) ? AMT_W'($urandom)
                                      : AMT_W'(int'($urandom_range(0, 40000)) - 20000);
            default:       c.amount = AMT_W'($urandom);
        endcase
        if (pick == 4) c.amount = AMT_W'($urandom);
        return c;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            tx_gap <= 0;
        end else if (req_if.valid && !req_if.ready) begin
        end else if (tx_gap > 0 || hold_input) begin
            req_if.valid <= 1'b0;
            if (tx_gap > 0) tx_gap <= tx_gap - 1;
        end else if (cmd_q.size() > 0) begin
            {req_if.func, req_if.set_year, req_if.set_month, req_if.set_day,
             req_if.amount} <= cmd_q[0];
            date_q.insert(date_q.size(), calendar_step(cmd_q.pop_front()));
            req_if.valid <= 1'b1;
            tx_gap <= $urandom_range(0, 4);
        end else begin
            req_if.valid <= 1'b0;
        end
    end

    // long receiver stall
    initial begin
        rx_hold = 1'b0;
        @(posedge i_clk iff hold_go);
        rx_hold <= 1'b1;
        repeat (3000) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin
        t_date_rsp got;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            rx_gap <= 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got = {rsp_if.year, rsp_if.month, rsp_if.day, rsp_if.weekday,
                       rsp_if.day_count, rsp_if.status};
                if (date_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected transaction %p", got);
                end else begin
                    if (got !== date_q[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", date_q[0], got);
                    end
                    void'(date_q.pop_front());
                end
            end
            if (rx_hold) begin
                rsp_if.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rsp_if.ready <= 1'b0;
                rx_gap <= rx_gap - 1;
            end else begin
                rsp_if.ready <= 1'b1;
                if (rsp_if.valid && rsp_if.ready) rx_gap <= $urandom_range(0, 4);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 4000000) begin
            $display("** epoch_day_calendar_engine_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        stored_days = 0;
        mismatches = 0;
        cycle_cnt = 0;
        hold_go = 1'b0;
        hold_input = 1'b0;
        req_if.valid = 1'b0;
        req_if.func = '0;
        req_if.set_year = '0;
        req_if.set_month = '0;
        req_if.set_day = '0;
        req_if.amount = '0;
        rsp_if.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_cmd(make_cmd(FN_READ, 0, 0, 0, 0));
        queue_cmd(make_cmd(FN_SET, 2000, 13, 1, 0));
        queue_cmd(make_cmd(FN_SET, 2000, 0, 1, 0));
        queue_cmd(make_cmd(FN_SET, 1969, 5, 1, 0));
        queue_cmd(make_cmd(FN_SET, 2226, 5, 1, 0));
        queue_cmd(make_cmd(FN_SET, 4095, 15, 31, 0));
        queue_cmd(make_cmd(FN_SET, 2001, 2, 29, 0));
        queue_cmd(make_cmd(FN_SET, 2001, 2, 0, 0));
        queue_cmd(make_cmd(FN_SET, 2225, 12, 31, 0));
        queue_cmd(make_cmd(FN_ADD_DAYS, 0, 0, 0, 1));
        queue_cmd(make_cmd(FN_SET, 2000, 2, 29, 0));
        queue_cmd(make_cmd(FN_ADD_YEARS, 0, 0, 0, 1));
        queue_cmd(make_cmd(FN_SET, 2000, 2, 29, 0));
        queue_cmd(make_cmd(FN_ADD_YEARS, 0, 0, 0, 0));
        queue_cmd(make_cmd(FN_ADD_YEARS, 0, 0, 0, -31));
        queue_cmd(make_cmd(FN_ADD_YEARS, 0, 0, 0, 226));
        queue_cmd(make_cmd(FN_SET, 2000, 1, 31, 0));
        queue_cmd(make_cmd(FN_ADD_MONTHS, 0, 0, 0, 1));
        queue_cmd(make_cmd(FN_ADD_MONTHS, 0, 0, 0, -3));
        queue_cmd(make_cmd(FN_ADD_MONTHS, 0, 0, 0, -131072));
        queue_cmd(make_cmd(FN_ADD_MONTHS, 0, 0, 0, 131071));
        queue_cmd(make_cmd(FN_ADD_DAYS, 0, 0, 0, -131072));
        queue_cmd(make_cmd(FN_ADD_DAYS, 0, 0, 0, 131071));
        queue_cmd(make_cmd(7, 4095, 15, 31, -1));
        queue_cmd(make_cmd(FN_SET, 1970, 1, 1, 0));

        for (int i = 0; i < 1350; i++) begin
            queue_cmd(random_cmd());
            if (i == 400) begin
                // long receiver stall while the sender keeps offering
                wait (cmd_q.size() < 20);
                hold_go = 1'b1;
            end
            if (i == 800) begin
                // sender pauses until everything has drained
                wait (cmd_q.size() == 0);
                hold_input <= 1'b1;
                wait (date_q.size() == 0);
                @(posedge i_clk);
                hold_input <= 1'b0;
            end
        end
        wait (cmd_q.size() == 0);
        wait (date_q.size() == 0);
        repeat (600) @(posedge i_clk);
        if (mismatches == 0 && date_q.size() == 0) begin
            $display("** epoch_day_calendar_engine_unit: PASSED **");
        end else begin
            $display("** epoch_day_calendar_engine_unit: FAILED **");
        end
        $finish;
    end

endmodule

// File: files.f
design/edce_pkg.sv
design/edce_if.sv
design/edce_ctrl.sv
design/edce_datapath.sv
design/epoch_day_calendar_engine_unit.sv
tb/sv/tb.sv
